// ----- hdl/aou_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aou_pkg
// Shared types, field widths and register codes of the Adam update pipeline.
// ----------------------------------------------------------------------------
package aou_pkg;

  // Bits of the step count taken by the power chain
  localparam int STEP_BITS = 20;

  // Configuration port
  localparam int CFG_BITS     = 32;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEARN_RATE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_FIRST  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY_SECOND = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EPSILON      = 2'd3;

  localparam logic [CFG_BITS-1:0] RST_LEARN_RATE   = 32'd4294967;
  localparam logic [CFG_BITS-1:0] RST_DECAY_FIRST  = 32'd3865470566;
  localparam logic [CFG_BITS-1:0] RST_DECAY_SECOND = 32'd4290672329;
  localparam logic [CFG_BITS-1:0] RST_EPSILON      = 32'd43;

  // Internal widths
  localparam int CORR_BITS     = 33;   // 1 - beta^t, Q1.32, up to one
  localparam int DIV1_NUM_BITS = 112;  // v' * 2^64
  localparam int DIV1_SPS      = 4;    // quotient bits per divider stage
  localparam int SQRT_IN_BITS  = 114;  // rounded v_hat, padded to even
  localparam int ROOT_BITS     = SQRT_IN_BITS / 2;
  localparam int DEN_BITS      = ROOT_BITS + 1;
  localparam int PDEN_BITS     = CORR_BITS + DEN_BITS;  // c1 * D
  localparam int DIV2_NUM_BITS = 34;   // quotient bits below the clamp check

  typedef struct packed {
    logic signed [31:0]    weight_in;
    logic signed [31:0]    gradient;
    logic signed [31:0]    moment_one_in;
    logic [47:0]           moment_two_in;
    logic [STEP_BITS-1:0]  step_count;
  } aou_in_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic signed [31:0] moment_one_out;
    logic [47:0]        moment_two_out;
  } aou_out_t;

  // Weight and updated moments, carried down the pipe
  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] moment_one;
    logic [47:0]        moment_two;
  } aou_mom_t;

  typedef struct packed {
    aou_mom_t             mom;
    logic [CORR_BITS-1:0] corr_first;
  } aou_carry_t;

  typedef struct packed {
    aou_mom_t mom;
    logic     clamp;
  } aou_tail_t;

endpackage

// ----- hdl/aou_moment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aou_moment
// Five-stage moment update: m' = b1*m + (1-b1)*g, v' = b2*v + (1-b2)*g^2.
// ----------------------------------------------------------------------------
module aou_moment (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  aou_pkg::aou_in_t                 item_i,
  input  logic [aou_pkg::CFG_BITS-1:0]     beta_a_i,
  input  logic [aou_pkg::CFG_BITS-1:0]     beta_b_i,
  output logic                             vld_o,
  output aou_pkg::aou_mom_t                mom_o,
  output logic [aou_pkg::STEP_BITS-1:0]    step_o
);

  localparam int DLY = 5;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  logic [DLY-1:0] vld_r;
  logic signed [31:0] w_r [DLY];
  logic [aou_pkg::STEP_BITS-1:0] t_r [DLY];
  logic signed [31:0] m_r [DLY-1];

  // stage 1
  logic signed [65:0] pm_nxt, pg_nxt, pm_r, pg_r;
  logic [63:0] gsq_nxt, gsq_r;
  logic [55:0] pvl_nxt, pvh_nxt, pvl_r, pvh_r;
  logic [32:0] cb1;
  logic [31:0] g_u, gmag;
  // stage 2
  logic signed [65:0] msum;
  logic signed [33:0] mq;
  logic signed [31:0] m_nxt;
  logic [63:0] g2sum;
  logic [46:0] g2_r;
  logic [79:0] pv_nxt, pv_r [3];
  // stage 3
  logic [32:0] cb2;
  logic [56:0] pgl_nxt, pgl_r;
  logic [55:0] pgh_nxt, pgh_r;
  // stage 4
  logic [79:0] pgs_nxt, pgs_r;
  // stage 5
  logic [81:0] acc;
  logic [47:0] v_nxt, v_r;

  always_comb begin
    cb1     = ONE_Q32 - {1'b0, beta_a_i};
    g_u     = item_i.gradient;
    gmag    = g_u[31] ? (~g_u + 32'd1) : g_u;
    pm_nxt  = $signed({1'b0, beta_a_i}) * $signed(item_i.moment_one_in);
    pg_nxt  = $signed({1'b0, cb1}) * $signed(item_i.gradient);
    gsq_nxt = 64'(gmag) * 64'(gmag);
    pvl_nxt = 56'(beta_b_i) * 56'(item_i.moment_two_in[23:0]);
    pvh_nxt = 56'(beta_b_i) * 56'(item_i.moment_two_in[47:24]);
  end

  always_comb begin
    msum = pm_r + pg_r + 66'sd2147483648;
    mq   = $signed(msum[65:32]);
    if (mq > 34'sd2147483647) begin
      m_nxt = 32'sh7FFF_FFFF;
    end else if (mq < -34'sd2147483648) begin
      m_nxt = 32'sh8000_0000;
    end else begin
      m_nxt = mq[31:0];
    end
    g2sum  = gsq_r + 64'h8000;
    pv_nxt = {pvh_r, 24'h0} + 80'(pvl_r);
  end

  always_comb begin
    cb2     = ONE_Q32 - {1'b0, beta_b_i};
    pgl_nxt = 57'(cb2) * 57'(g2_r[23:0]);
    pgh_nxt = 56'(cb2) * 56'(g2_r[46:24]);
    pgs_nxt = {pgh_r, 24'h0} + 80'(pgl_r);
    acc     = 82'(pv_r[2]) + 82'(pgs_r) + 82'h8000_0000;
    v_nxt   = (|acc[81:80]) ? '1 : acc[79:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= DLY'({vld_r, vld_i});
    end
  end

  always_ff @(posedge clk) begin
    pm_r  <= pm_nxt;
    pg_r  <= pg_nxt;
    gsq_r <= gsq_nxt;
    pvl_r <= pvl_nxt;
    pvh_r <= pvh_nxt;
    g2_r  <= g2sum[62:16];
    pv_r[0] <= pv_nxt;
    pv_r[1] <= pv_r[0];
    pv_r[2] <= pv_r[1];
    pgl_r <= pgl_nxt;
    pgh_r <= pgh_nxt;
    pgs_r <= pgs_nxt;
    v_r   <= v_nxt;
    w_r[0] <= item_i.weight_in;
    t_r[0] <= item_i.step_count;
    m_r[0] <= m_nxt;
    for (int k = 1; k < DLY; k++) begin
      w_r[k] <= w_r[k-1];
      t_r[k] <= t_r[k-1];
    end
    for (int k = 1; k < DLY - 1; k++) begin
      m_r[k] <= m_r[k-1];
    end
  end

  assign vld_o            = vld_r[DLY-1];
  assign mom_o.weight     = w_r[DLY-1];
  assign mom_o.moment_one = m_r[DLY-2];
  assign mom_o.moment_two = v_r;
  assign step_o           = t_r[DLY-1];

endmodule

// ----- hdl/aou_power.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aou_power
// Bias corrections 1 - beta^t for two betas, one square-and-multiply stage
// per step bit, then a final subtract stage.
// ----------------------------------------------------------------------------
module aou_power #(
  parameter int N  = aou_pkg::STEP_BITS,
  parameter int PW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [N-1:0]                  step_i,
  input  logic [aou_pkg::CFG_BITS-1:0]  beta_a_i,
  input  logic [aou_pkg::CFG_BITS-1:0]  beta_b_i,
  input  logic [PW-1:0]                 pay_i,
  output logic                          vld_o,
  output logic [aou_pkg::CORR_BITS-1:0] corr_a_o,
  output logic [aou_pkg::CORR_BITS-1:0] corr_b_o,
  output logic [PW-1:0]                 pay_o
);

  localparam int CW = aou_pkg::CORR_BITS;
  localparam logic [CW-1:0]  ONE_Q32  = {1'b1, 32'h0};
  localparam logic [CW+31:0] HALF_P   = (CW+32)'(32'h8000_0000);
  localparam logic [63:0]    HALF_SQ  = 64'h8000_0000;

  logic [N-1:0]  vld_r;
  logic [CW-1:0] ra_r [N];
  logic [CW-1:0] rb_r [N];
  logic [31:0]   ba_r [N];
  logic [31:0]   bb_r [N];
  logic [N-1:0]  t_r  [N];
  logic [PW-1:0] pay_r [N];

  logic          vout_r;
  logic [CW-1:0] ca_r, cb_r, ca_nxt, cb_nxt;
  logic [PW-1:0] pout_r;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [CW-1:0]   ra_src, rb_src, ra_nxt, rb_nxt;
    logic [31:0]     ba_src, bb_src, ba_nxt, bb_nxt;
    logic [N-1:0]    t_src;
    logic [PW-1:0]   pay_src;
    logic [CW+31:0]  pa, pb;
    logic [63:0]     sa, sb;

    if (s == 0) begin : g_first
      assign ra_src  = ONE_Q32;
      assign rb_src  = ONE_Q32;
      assign ba_src  = beta_a_i;
      assign bb_src  = beta_b_i;
      assign t_src   = step_i;
      assign pay_src = pay_i;
    end else begin : g_next
      assign ra_src  = ra_r[s-1];
      assign rb_src  = rb_r[s-1];
      assign ba_src  = ba_r[s-1];
      assign bb_src  = bb_r[s-1];
      assign t_src   = t_r[s-1];
      assign pay_src = pay_r[s-1];
    end

    always_comb begin
      pa     = (CW+32)'(ra_src) * (CW+32)'(ba_src);
      pb     = (CW+32)'(rb_src) * (CW+32)'(bb_src);
      sa     = 64'(ba_src) * 64'(ba_src);
      sb     = 64'(bb_src) * 64'(bb_src);
      ra_nxt = t_src[s] ? CW'((pa + HALF_P) >> 32) : ra_src;
      rb_nxt = t_src[s] ? CW'((pb + HALF_P) >> 32) : rb_src;
      ba_nxt = 32'((sa + HALF_SQ) >> 32);
      bb_nxt = 32'((sb + HALF_SQ) >> 32);
    end

    always_ff @(posedge clk) begin
      ra_r[s]  <= ra_nxt;
      rb_r[s]  <= rb_nxt;
      ba_r[s]  <= ba_nxt;
      bb_r[s]  <= bb_nxt;
      t_r[s]   <= t_src;
      pay_r[s] <= pay_src;
    end
  end

  // Turn b^t into 1 - b^t; a zero correction becomes the smallest step
  always_comb begin
    ca_nxt = ONE_Q32 - ra_r[N-1];
    cb_nxt = ONE_Q32 - rb_r[N-1];
    if (ca_nxt == '0) ca_nxt = CW'(1);
    if (cb_nxt == '0) cb_nxt = CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vout_r <= 1'b0;
    end else begin
      vld_r  <= N'({vld_r, vld_i});
      vout_r <= vld_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    pout_r <= pay_r[N-1];
  end

  assign vld_o    = vout_r;
  assign corr_a_o = ca_r;
  assign corr_b_o = cb_r;
  assign pay_o    = pout_r;

endmodule

// ----- hdl/aou_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aou_div
// Pipelined restoring divider, SPS quotient bits per stage. The starting
// remainder must be below the divisor.
// ----------------------------------------------------------------------------
module aou_div #(
  parameter int NW  = aou_pkg::DIV1_NUM_BITS,
  parameter int DW  = aou_pkg::CORR_BITS,
  parameter int SPS = aou_pkg::DIV1_SPS,
  parameter int PW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [PW-1:0] pay_o
);

  localparam int NS = NW / SPS;

  logic [NS-1:0] vld_r;
  logic [NW-1:0] nq_r  [NS];
  logic [DW-1:0] rem_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [PW-1:0] pay_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [NW-1:0] nq_src, nq_nxt;
    logic [DW-1:0] rem_src, rem_nxt, den_src;
    logic [PW-1:0] pay_src;

    if (s == 0) begin : g_first
      assign nq_src  = num_i;
      assign rem_src = rem_i;
      assign den_src = den_i;
      assign pay_src = pay_i;
    end else begin : g_next
      assign nq_src  = nq_r[s-1];
      assign rem_src = rem_r[s-1];
      assign den_src = den_r[s-1];
      assign pay_src = pay_r[s-1];
    end

    // Shift the next numerator bit in, subtract where it fits
    always_comb begin
      logic [DW:0] trial;
      trial   = '0;
      nq_nxt  = nq_src;
      rem_nxt = rem_src;
      for (int k = 0; k < SPS; k++) begin
        trial  = {rem_nxt, nq_nxt[NW-1]};
        nq_nxt = {nq_nxt[NW-2:0], 1'b0};
        if (trial >= {1'b0, den_src}) begin
          rem_nxt   = DW'(trial - {1'b0, den_src});
          nq_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      nq_r[s]  <= nq_nxt;
      rem_r[s] <= rem_nxt;
      den_r[s] <= den_src;
      pay_r[s] <= pay_src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= NS'({vld_r, vld_i});
    end
  end

  assign vld_o = vld_r[NS-1];
  assign quo_o = nq_r[NS-1];
  assign rem_o = rem_r[NS-1];
  assign den_o = den_r[NS-1];
  assign pay_o = pay_r[NS-1];

endmodule

// ----- hdl/aou_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aou_sqrt
// Pipelined digit-by-digit square root, SPS root bits per stage; returns
// the floor root and the remainder x - root^2.
// ----------------------------------------------------------------------------
module aou_sqrt #(
  parameter int XW  = aou_pkg::SQRT_IN_BITS,
  parameter int SPS = 1,
  parameter int PW  = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  input  logic [XW-1:0]     x_i,
  input  logic [PW-1:0]     pay_i,
  output logic              vld_o,
  output logic [XW/2-1:0]   root_o,
  output logic [XW/2:0]     rem_o,
  output logic [PW-1:0]     pay_o
);

  localparam int H  = XW / 2;
  localparam int NS = H / SPS;

  logic [NS-1:0] vld_r;
  logic [XW-1:0] xs_r   [NS];
  logic [H-1:0]  root_r [NS];
  logic [H:0]    rem_r  [NS];
  logic [PW-1:0] pay_r  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [XW-1:0] xs_src, xs_nxt;
    logic [H-1:0]  root_src, root_nxt;
    logic [H:0]    rem_src, rem_nxt;
    logic [PW-1:0] pay_src;

    if (s == 0) begin : g_first
      assign xs_src   = x_i;
      assign root_src = '0;
      assign rem_src  = '0;
      assign pay_src  = pay_i;
    end else begin : g_next
      assign xs_src   = xs_r[s-1];
      assign root_src = root_r[s-1];
      assign rem_src  = rem_r[s-1];
      assign pay_src  = pay_r[s-1];
    end

    // Bring down two bits, try root*4+1
    always_comb begin
      logic [H+2:0] cand, trial;
      cand     = '0;
      trial    = '0;
      xs_nxt   = xs_src;
      root_nxt = root_src;
      rem_nxt  = rem_src;
      for (int k = 0; k < SPS; k++) begin
        cand   = {rem_nxt, xs_nxt[XW-1:XW-2]};
        trial  = {1'b0, root_nxt, 2'b01};
        xs_nxt = {xs_nxt[XW-3:0], 2'b00};
        if (cand >= trial) begin
          rem_nxt  = (H+1)'(cand - trial);
          root_nxt = {root_nxt[H-2:0], 1'b1};
        end else begin
          rem_nxt  = (H+1)'(cand);
          root_nxt = {root_nxt[H-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      xs_r[s]   <= xs_nxt;
      root_r[s] <= root_nxt;
      rem_r[s]  <= rem_nxt;
      pay_r[s]  <= pay_src;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= NS'({vld_r, vld_i});
    end
  end

  assign vld_o  = vld_r[NS-1];
  assign root_o = root_r[NS-1];
  assign rem_o  = rem_r[NS-1];
  assign pay_o  = pay_r[NS-1];

endmodule

// ----- hdl/adam_optimizer_update.sv -----
`timescale 1ns / 1ps
// A started word passes the moment update, the bias corrections, the 112-bit v_hat
//   divider, the 57-step root and the 34-bit update divider before its result strobes.
// Throughput: one word per cycle; busy never rises and the pipe never stalls.
// Reset (rst_n low, synchronous): all valid bits clear, config registers take defaults.
// The receiver cannot stall: each result word is on out_data for one cycle.
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Per-element Adam step with bias correction in fixed point: moment update,
// 1 - beta^t corrections, sqrt(v_hat) + eps, and the saturated weight move.
// ----------------------------------------------------------------------------
module adam_optimizer_update (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command side
  input  logic                                 start,
  output logic                                 busy,
  input  aou_pkg::aou_in_t                     in_data,
  // result side
  output logic                                 out_strobe,
  output aou_pkg::aou_out_t                    out_data,
  // configuration
  input  logic                                 cfg_we,
  input  logic [aou_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [aou_pkg::CFG_BITS-1:0]         cfg_data
);

  localparam int CW     = aou_pkg::CORR_BITS;
  localparam int DNW    = aou_pkg::DEN_BITS;
  localparam int RTW    = aou_pkg::ROOT_BITS;
  localparam int XW     = aou_pkg::SQRT_IN_BITS;
  localparam int N1     = aou_pkg::DIV1_NUM_BITS;
  localparam int N2     = aou_pkg::DIV2_NUM_BITS;
  localparam int PDW    = aou_pkg::PDEN_BITS;
  localparam int DLO    = DNW / 2;               // low slice of D for c1*D
  localparam int MOM_W  = $bits(aou_pkg::aou_mom_t);
  localparam int CAR_W  = $bits(aou_pkg::aou_carry_t);
  localparam int TAIL_W = $bits(aou_pkg::aou_tail_t);
  localparam logic [N2:0] UPD_MAX = (N2+1)'(35'h2_0000_0000);

  // --------------------------------------------------------------------------
  // Configuration registers; not enforced by the block, the user must see they are written only while the pipe is empty
  // --------------------------------------------------------------------------
  logic [31:0] lr_r, b1_r, b2_r, eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= aou_pkg::RST_LEARN_RATE;
      b1_r  <= aou_pkg::RST_DECAY_FIRST;
      b2_r  <= aou_pkg::RST_DECAY_SECOND;
      eps_r <= aou_pkg::RST_EPSILON;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aou_pkg::REG_LEARN_RATE:   lr_r  <= cfg_data;
        aou_pkg::REG_DECAY_FIRST:  b1_r  <= cfg_data;
        aou_pkg::REG_DECAY_SECOND: b2_r  <= cfg_data;
        aou_pkg::REG_EPSILON:      eps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe always advances, so every start is taken
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Moments
  // --------------------------------------------------------------------------
  logic                            mom_vld;
  aou_pkg::aou_mom_t               mom;
  logic [aou_pkg::STEP_BITS-1:0]   mom_step;

  aou_moment u_moment (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (start & ~busy),
    .item_i   (in_data),
    .beta_a_i (b1_r),
    .beta_b_i (b2_r),
    .vld_o    (mom_vld),
    .mom_o    (mom),
    .step_o   (mom_step)
  );

  // --------------------------------------------------------------------------
  // Bias corrections
  // --------------------------------------------------------------------------
  logic              pw_vld;
  logic [CW-1:0]     corr1, corr2;
  logic [MOM_W-1:0]  pw_pay;
  aou_pkg::aou_mom_t pw_mom;
  aou_pkg::aou_carry_t pw_carry;

  aou_power #(
    .N  (aou_pkg::STEP_BITS),
    .PW (MOM_W)
  ) u_power (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (mom_vld),
    .step_i   (mom_step),
    .beta_a_i (b1_r),
    .beta_b_i (b2_r),
    .pay_i    (mom),
    .vld_o    (pw_vld),
    .corr_a_o (corr1),
    .corr_b_o (corr2),
    .pay_o    (pw_pay)
  );

  assign pw_mom              = pw_pay;
  assign pw_carry.mom        = pw_mom;
  assign pw_carry.corr_first = corr1;

  // --------------------------------------------------------------------------
  // v_hat = v' * 2^64 / c2
  // --------------------------------------------------------------------------
  logic              d1_vld;
  logic [N1-1:0]     d1_quo;
  logic [CW-1:0]     d1_rem, d1_den;
  logic [CAR_W-1:0]  d1_pay;

  aou_div #(
    .NW  (N1),
    .DW  (CW),
    .SPS (aou_pkg::DIV1_SPS),
    .PW  (CAR_W)
  ) u_div_vhat (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (pw_vld),
    .num_i ({pw_mom.moment_two, 64'h0}),
    .rem_i ('0),
    .den_i (corr2),
    .pay_i (pw_carry),
    .vld_o (d1_vld),
    .quo_o (d1_quo),
    .rem_o (d1_rem),
    .den_o (d1_den),
    .pay_o (d1_pay)
  );

  // round the quotient: up when twice the remainder reaches the divisor
  logic              r1_vld_r;
  logic [XW-1:0]     x_r;
  logic [CAR_W-1:0]  r1_pay_r;

  always_ff @(posedge clk) begin
    x_r      <= XW'(d1_quo) + XW'(({d1_rem, 1'b0} >= {1'b0, d1_den}) ? 1'b1 : 1'b0);
    r1_pay_r <= d1_pay;
  end

  // --------------------------------------------------------------------------
  // sqrt(v_hat)
  // --------------------------------------------------------------------------
  logic              sq_vld;
  logic [RTW-1:0]    sq_root;
  logic [RTW:0]      sq_rem;
  logic [CAR_W-1:0]  sq_pay;

  aou_sqrt #(
    .XW  (XW),
    .SPS (1),
    .PW  (CAR_W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (r1_vld_r),
    .x_i    (x_r),
    .pay_i  (r1_pay_r),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .rem_o  (sq_rem),
    .pay_o  (sq_pay)
  );

  aou_pkg::aou_carry_t sq_carry;
  assign sq_carry = sq_pay;

  // --------------------------------------------------------------------------
  // D = round(sqrt) + eps, |m'|, then c1*D and lr*|m'|
  // --------------------------------------------------------------------------
  logic                r2_vld_r, r3_vld_r, r4_vld_r, r5_vld_r;
  logic [DNW-1:0]      den_sum, den2_r;
  logic [31:0]         m_u, mmag_nxt, mmag2_r;
  aou_pkg::aou_carry_t car2_r;
  logic [CW+DLO-1:0]   cdl_r;
  logic [CW+DNW-DLO-1:0] cdh_r;
  logic [63:0]         prod3_r, prod4_r;
  aou_pkg::aou_mom_t   mom3_r, mom4_r;
  logic [PDW-1:0]      dprod_r;
  logic [PDW-1:0]      top_nxt;

  always_comb begin
    den_sum = DNW'(sq_root) + DNW'(sq_carry.mom.moment_two[0] & 1'b0)
            + DNW'(eps_r) + DNW'((sq_rem > {1'b0, sq_root}) ? 1'b1 : 1'b0);
    if (den_sum == '0) den_sum = DNW'(1);
    m_u      = sq_carry.mom.moment_one;
    mmag_nxt = m_u[31] ? (~m_u + 32'd1) : m_u;
  end

  always_ff @(posedge clk) begin
    den2_r  <= den_sum;
    mmag2_r <= mmag_nxt;
    car2_r  <= sq_carry;
    // split c1*D into two partial products
    cdl_r   <= (CW+DLO)'(car2_r.corr_first) * (CW+DLO)'(den2_r[DLO-1:0]);
    cdh_r   <= (CW+DNW-DLO)'(car2_r.corr_first) * (CW+DNW-DLO)'(den2_r[DNW-1:DLO]);
    prod3_r <= 64'(lr_r) * 64'(mmag2_r);
    mom3_r  <= car2_r.mom;
    dprod_r <= {cdh_r, DLO'(0)} + PDW'(cdl_r);
    prod4_r <= prod3_r;
    mom4_r  <= mom3_r;
  end

  // --------------------------------------------------------------------------
  // Clamp check and update divider: U = lr*|m'|*2^32 / (c1*D)
  // --------------------------------------------------------------------------
  logic [PDW-1:0]     rem5_r, den5_r;
  logic [N2-1:0]      num5_r;
  aou_pkg::aou_tail_t tail5_r;

  // quotient reaches 2^34 exactly when the numerator top bits reach the divisor
  assign top_nxt = PDW'(prod4_r[63:2]);

  always_ff @(posedge clk) begin
    rem5_r       <= (top_nxt >= dprod_r) ? '0 : top_nxt;
    num5_r       <= {prod4_r[1:0], 32'h0};
    den5_r       <= dprod_r;
    tail5_r.mom  <= mom4_r;
    tail5_r.clamp <= (top_nxt >= dprod_r);
  end

  logic              d2_vld;
  logic [N2-1:0]     d2_quo;
  logic [PDW-1:0]    d2_rem, d2_den;
  logic [TAIL_W-1:0] d2_pay;
  aou_pkg::aou_tail_t d2_tail;

  aou_div #(
    .NW  (N2),
    .DW  (PDW),
    .SPS (1),
    .PW  (TAIL_W)
  ) u_div_upd (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (r5_vld_r),
    .num_i (num5_r),
    .rem_i (rem5_r),
    .den_i (den5_r),
    .pay_i (tail5_r),
    .vld_o (d2_vld),
    .quo_o (d2_quo),
    .rem_o (d2_rem),
    .den_o (d2_den),
    .pay_o (d2_pay)
  );

  assign d2_tail = d2_pay;

  // --------------------------------------------------------------------------
  // Round and clamp U, then move the weight and saturate
  // --------------------------------------------------------------------------
  logic              r6_vld_r, out_vld_r;
  logic [N2:0]       q_rnd;
  logic [N2-1:0]     upd6_r;
  aou_pkg::aou_mom_t mom6_r;
  logic signed [N2+1:0] wsum;
  aou_pkg::aou_out_t out_r, out_nxt;

  always_comb begin
    q_rnd = (N2+1)'(d2_quo) + (N2+1)'(({d2_rem, 1'b0} >= {1'b0, d2_den}) ? 1'b1 : 1'b0);
  end

  always_ff @(posedge clk) begin
    upd6_r <= (d2_tail.clamp || (q_rnd > UPD_MAX)) ? UPD_MAX[N2-1:0] : q_rnd[N2-1:0];
    mom6_r <= d2_tail.mom;
  end

  always_comb begin
    if (mom6_r.moment_one[31]) begin
      wsum = (N2+2)'(mom6_r.weight) + $signed({2'b00, upd6_r});
    end else begin
      wsum = (N2+2)'(mom6_r.weight) - $signed({2'b00, upd6_r});
    end
    if (wsum > (N2+2)'(32'sh7FFF_FFFF)) begin
      out_nxt.weight_out = 32'sh7FFF_FFFF;
    end else if (wsum < (N2+2)'(32'sh8000_0000)) begin
      out_nxt.weight_out = 32'sh8000_0000;
    end else begin
      out_nxt.weight_out = wsum[31:0];
    end
    out_nxt.moment_one_out = mom6_r.moment_one;
    out_nxt.moment_two_out = mom6_r.moment_two;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid bits of the glue stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r  <= 1'b0;
      r2_vld_r  <= 1'b0;
      r3_vld_r  <= 1'b0;
      r4_vld_r  <= 1'b0;
      r5_vld_r  <= 1'b0;
      r6_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      r1_vld_r  <= d1_vld;
      r2_vld_r  <= sq_vld;
      r3_vld_r  <= r2_vld_r;
      r4_vld_r  <= r3_vld_r;
      r5_vld_r  <= r4_vld_r;
      r6_vld_r  <= d2_vld;
      out_vld_r <= r6_vld_r;
    end
  end

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

// ----- sim/adam_optimizer_update_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_optimizer_update_test
// Self-checking bench for the Adam update pipeline. An in-bench predictor
// computes each expected word in wide integer arithmetic from the shadowed
// register values. Directed corner words, register sweeps and constrained-free
// random traffic with bursty start gaps are pushed through, and every result
// strobe is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module adam_optimizer_update_test;

  localparam int HALF_PERIOD = 6;
  localparam int PIPE_DEPTH  = 131 + aou_pkg::STEP_BITS;   // used for the final wait after the drain
  localparam int STALL_LIMIT = 4000;                       // cycles with no handshake at all

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  aou_pkg::aou_in_t  in_data;
  logic          out_strobe;
  aou_pkg::aou_out_t out_data;
  logic          cfg_we;
  logic [aou_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [aou_pkg::CFG_BITS-1:0]     cfg_data;

  // Shadow copies of the four rate registers
  logic [31:0] lr_q, beta1_q, beta2_q, eps_q;

  aou_pkg::aou_out_t pending_words[$];
  int       mismatches;
  int       quiet_cycles;
  bit       gaps_on;

  adam_optimizer_update uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Quotient rounded to nearest, ties up
  function automatic logic [127:0] div_nearest(logic [127:0] num, logic [127:0] den);
    logic [127:0] quo, rem;
    quo = num / den;
    rem = num % den;
    if (den - rem <= rem) quo = quo + 1;
    return quo;
  endfunction

  // Root of a value below 2^114, rounded to nearest
  function automatic logic [127:0] sqrt_nearest(logic [127:0] x);
    logic [127:0] root, trial;
    root = '0;
    for (int b = 56; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    if (x > root * root + root) root = root + 1;
    return root;
  endfunction

  // One minus beta^t in Q1.32; a zero correction is taken as the smallest step
  function automatic logic [127:0] bias_corr(logic [31:0] beta,
                                             logic [aou_pkg::STEP_BITS-1:0] t);
    logic [127:0] pw, base;
    pw   = 128'h1_0000_0000;
    base = {96'd0, beta};
    for (int i = 0; i < aou_pkg::STEP_BITS; i++) begin
      if (t[i]) pw = (pw * base + 128'h8000_0000) >> 32;
      base = (base * base + 128'h8000_0000) >> 32;
    end
    pw = 128'h1_0000_0000 - pw;
    return (pw == 0) ? 128'd1 : pw;
  endfunction

  function automatic logic [31:0] sat_word(logic signed [95:0] x);
    if (x > 96'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -96'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic aou_pkg::aou_out_t adam_predict(aou_pkg::aou_in_t x);
    logic signed [95:0] b96, nb96, m96, g96, mix, m_new, w_new;
    logic [127:0] gmag, g2, acc, v_new, c1, c2, root, den, mmag, upd;
    aou_pkg::aou_out_t res;
    b96  = $signed({64'd0, beta1_q});
    nb96 = 96'sh1_0000_0000 - b96;
    m96  = x.moment_one_in;
    g96  = x.gradient;
    mix  = b96 * m96 + nb96 * g96;
    m_new = $signed(sat_word((mix + 96'sd2147483648) >>> 32));

    gmag = (g96 < 0) ? 128'(-g96) : 128'(g96);
    g2   = (gmag * gmag + 128'h8000) >> 16;
    acc  = 128'(beta2_q) * 128'(x.moment_two_in)
         + (128'h1_0000_0000 - 128'(beta2_q)) * g2 + 128'h8000_0000;
    v_new = acc >> 32;
    if (v_new > 128'hFFFF_FFFF_FFFF) v_new = 128'hFFFF_FFFF_FFFF;

    c1 = bias_corr(beta1_q, x.step_count);
    c2 = bias_corr(beta2_q, x.step_count);

    root = sqrt_nearest(div_nearest(v_new << 64, c2));
    den  = root + 128'(eps_q);
    if (den == 0) den = 128'd1;

    mmag = (m_new < 0) ? 128'(-m_new) : 128'(m_new);
    acc  = div_nearest((128'(lr_q) * mmag) << 32, c1 * den);
    upd  = (acc > 128'h2_0000_0000) ? 128'h2_0000_0000 : acc;

    w_new = (m_new < 0) ? 96'(x.weight_in) + $signed({32'd0, upd[63:0]})
                        : 96'(x.weight_in) - $signed({32'd0, upd[63:0]});

    res.weight_out     = sat_word(w_new);
    res.moment_one_out = m_new[31:0];
    res.moment_two_out = v_new[47:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake monitor: predict on every accepted command word, check every
  // result strobe against the oldest prediction, and watch for a hang.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    aou_pkg::aou_out_t want;
    if (rst_n) begin
      if (start && !busy) pending_words = {pending_words, adam_predict(in_data)};
      if (out_strobe) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none actual %h",
                   $time, out_data);
        end else begin
          want = pending_words.pop_front();
          if (out_data.weight_out !== want.weight_out) begin
            mismatches++;
            $display("%0t: weight_out expected %h actual %h",
                     $time, want.weight_out, out_data.weight_out);
          end
          if (out_data.moment_one_out !== want.moment_one_out) begin
            mismatches++;
            $display("%0t: moment_one_out expected %h actual %h",
                     $time, want.moment_one_out, out_data.moment_one_out);
          end
          if (out_data.moment_two_out !== want.moment_two_out) begin
            mismatches++;
            $display("%0t: moment_two_out expected %h actual %h",
                     $time, want.moment_two_out, out_data.moment_two_out);
          end
        end
      end
      // Any handshake on either side resets the hang counter
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Drive one command word and hold it until taken; maybe idle afterward
  task automatic send_word(aou_pkg::aou_in_t w);
    int gap;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop start and wait for every outstanding word to come back
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  // Write one rate register; only called with the pipe empty
  task automatic write_reg(logic [aou_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aou_pkg::REG_LEARN_RATE:   lr_q    = val;
      aou_pkg::REG_DECAY_FIRST:  beta1_q = val;
      aou_pkg::REG_DECAY_SECOND: beta2_q = val;
      default:                   eps_q   = val;
    endcase
  endtask

  task automatic load_regs(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2,
                           logic [31:0] eps);
    drain_pipe();
    write_reg(aou_pkg::REG_LEARN_RATE, lr);
    write_reg(aou_pkg::REG_DECAY_FIRST, b1);
    write_reg(aou_pkg::REG_DECAY_SECOND, b2);
    write_reg(aou_pkg::REG_EPSILON, eps);
  endtask

  function automatic aou_pkg::aou_in_t make_word(logic [31:0] w, logic [31:0] g,
                                                 logic [31:0] m, logic [47:0] v,
                                                 logic [aou_pkg::STEP_BITS-1:0] t);
    aou_pkg::aou_in_t x;
    x.weight_in     = w;
    x.gradient      = g;
    x.moment_one_in = m;
    x.moment_two_in = v;
    x.step_count    = t;
    return x;
  endfunction

  // Mostly training-like magnitudes, with full-range noise mixed in
  function automatic aou_pkg::aou_in_t random_word();
    aou_pkg::aou_in_t x;
    if ($urandom_range(0, 3) == 0) begin
      x = make_word($urandom, $urandom, $urandom, {16'($urandom), $urandom},
                    aou_pkg::STEP_BITS'($urandom));
    end else begin
      x.weight_in     = $signed(32'($urandom_range(0, 32'h01FF_FFFF))) - 32'sh0100_0000;
      x.gradient      = $signed(32'($urandom_range(0, 32'h00FF_FFFF))) - 32'sh0080_0000;
      x.moment_one_in = $signed(32'($urandom_range(0, 32'h007F_FFFF))) - 32'sh0040_0000;
      x.moment_two_in = 48'($urandom_range(0, 32'h0FFF_FFFF));
      x.step_count    = ($urandom_range(0, 3) == 0)
                      ? aou_pkg::STEP_BITS'($urandom_range(1, 100000))
                      : aou_pkg::STEP_BITS'($urandom_range(1, 60));
    end
    return x;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes and named corners under the default rates, then zero epsilon and full rates
  task automatic test_corners();
    send_word(make_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 20'd1));
    send_word(make_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 48'd0, 20'hFFFFF));
    send_word(make_word(32'h0, 32'h0, 32'h0, 48'd0, 20'd1));
    send_word(make_word(32'h0100_0000, 32'h0100_0000, 32'h0, 48'd0, 20'd1));
    send_word(make_word(32'hFF00_0000, 32'hFF00_0000, 32'h0, 48'd0, 20'd2));
    // zero correction: no set step bit
    send_word(make_word(32'h0100_0000, 32'h0080_0000, 32'h0040_0000, 48'h1_0000_0000, 20'd0));
    send_word(make_word(32'h7FFF_FFF0, 32'h8000_0000, 32'h8000_0000, 48'd0, 20'd0));
    send_word(make_word(32'h8000_0010, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'd0, 20'd3));
    send_word(make_word(32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001, 48'h0000_0000_0001,
                        20'd1000));
    send_word(make_word(32'h0, 32'h0000_0001, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 20'h80000));
    // zero denominator: no second moment and no guard
    load_regs(aou_pkg::RST_LEARN_RATE, aou_pkg::RST_DECAY_FIRST, aou_pkg::RST_DECAY_SECOND,
              32'd0);
    send_word(make_word(32'h0100_0000, 32'h0, 32'h0020_0000, 48'd0, 20'd1));
    send_word(make_word(32'h8000_0000, 32'h0, 32'hFFE0_0000, 48'd0, 20'd7));
    // huge update: full rate, tiny denominator, both signs of the move
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_word(make_word(32'h0, 32'h0, 32'h7FFF_FFFF, 48'd0, 20'd1));
    send_word(make_word(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 48'd0, 20'd1));
    send_word(make_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF,
                        20'hFFFFF));
    send_word(make_word(32'h0, 32'h0, 32'h0, 48'd0, 20'd0));
  endtask

  // Register extremes and the defaults, each with a batch of random words
  task automatic test_rate_sweep();
    logic [31:0] sweep[5][4];
    sweep[0] = '{32'd0, 32'd0, 32'd0, 32'd0};
    sweep[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    sweep[2] = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0};
    sweep[3] = '{32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000};
    sweep[4] = '{aou_pkg::RST_LEARN_RATE, aou_pkg::RST_DECAY_FIRST,
                 aou_pkg::RST_DECAY_SECOND, aou_pkg::RST_EPSILON};
    for (int p = 0; p < 5; p++) begin
      load_regs(sweep[p][0], sweep[p][1], sweep[p][2], sweep[p][3]);
      repeat (40) send_word(random_word());
    end
  endtask

  // Long random traffic across random rate settings
  task automatic test_random_stream();
    for (int p = 0; p < 8; p++) begin
      if (p == 0) load_regs(aou_pkg::RST_LEARN_RATE, aou_pkg::RST_DECAY_FIRST,
                            aou_pkg::RST_DECAY_SECOND, aou_pkg::RST_EPSILON);
      else load_regs($urandom, $urandom, $urandom, $urandom_range(0, 4096));
      repeat (175) send_word(random_word());
    end
  endtask

  // Back-to-back words with no gaps at the tail of the run
  task automatic test_full_rate();
    gaps_on = 1'b0;
    load_regs(aou_pkg::RST_LEARN_RATE, aou_pkg::RST_DECAY_FIRST,
              aou_pkg::RST_DECAY_SECOND, aou_pkg::RST_EPSILON);
    repeat (250) send_word(random_word());
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b1;
    lr_q         = aou_pkg::RST_LEARN_RATE;
    beta1_q      = aou_pkg::RST_DECAY_FIRST;
    beta2_q      = aou_pkg::RST_DECAY_SECOND;
    eps_q        = aou_pkg::RST_EPSILON;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_corners();
    test_rate_sweep();
    test_random_stream();
    test_full_rate();

    // Let the pipe empty, then allow a little more for any stray strobe
    drain_pipe();
    repeat (PIPE_DEPTH + 20) @(negedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/aou_pkg.sv
hdl/aou_moment.sv
hdl/aou_power.sv
hdl/aou_div.sv
hdl/aou_sqrt.sv
hdl/adam_optimizer_update.sv
sim/adam_optimizer_update_test.sv
